[rtl/pcrmv_pkg.sv]
// ----------------------------------------------------------------------------
// pcrmv_pkg
// Types and constants shared by the running mean and variance block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrmv_pkg;

    localparam int SAMPLE_W = 40;
    localparam int VAR_W    = 64;
    localparam int ARC_W    = 32;
    localparam int CFG_W    = 32;
    localparam logic [CFG_W-1:0] INIT_VAR_RESET = 32'd4096;

    typedef struct packed {
        logic [5:0]                 sat_index;
        logic                       value_present;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       arc_present;
        logic [ARC_W-1:0]           arc_number;
    } t_in_item;

    typedef struct packed {
        logic                       rejected;
        logic signed [SAMPLE_W-1:0] mean_out;
        logic [VAR_W-1:0]           variance_out;
        logic                       restarted;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic rd_entry;
        logic start_mean;
        logic start_var;
        logic wr_restart;
        logic wr_update;
        logic load_out_rej;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic reject;
        logic restart;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[rtl/pcrmv_div.sv]
// ----------------------------------------------------------------------------
// pcrmv_div
// Restoring divider, one quotient bit per cycle, unsigned 64 by count.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrmv_div
    import pcrmv_pkg::*;
#(
    parameter int DEN_W = 20
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [VAR_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    output logic                    o_done,
    output logic [VAR_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(VAR_W + 1);

    logic [VAR_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem,  n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial;

    // one shift and subtract step
    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_quot[VAR_W-1]};
        n_quot  = {r_quot[VAR_W-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VAR_W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[rtl/pcrmv_datapath.sv]
// ----------------------------------------------------------------------------
// pcrmv_datapath
// Channel tables, mean and variance update arithmetic, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrmv_datapath
    import pcrmv_pkg::*;
#(
    parameter int NUM_CHANNELS = 64,
    parameter int COUNT_BITS   = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire t_in_item         i_item,
    input  wire logic [CFG_W-1:0] i_init_var,
    input  wire logic             i_clr_en,
    input  wire logic [7:0]       i_clr_addr,
    output t_dp_sts               o_sts,
    output t_out_item             o_result
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int HALF_W = SAMPLE_W / 2;
    localparam int PROD_W = 2 * HALF_W;

    // channel tables
    logic [ARC_W-1:0]           m_arc  [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]      m_cnt  [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] m_mean [NUM_CHANNELS];
    logic [VAR_W-1:0]           m_var  [NUM_CHANNELS];

    t_in_item                   r_item;
    logic [IDX_W-1:0]           r_idx;
    logic [ARC_W-1:0]           r_arc;
    logic [COUNT_BITS-1:0]      r_cnt;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [VAR_W-1:0]           r_var;
    logic [COUNT_BITS-1:0]      r_n;
    logic                       r_dneg;
    logic [SAMPLE_W-1:0]        r_mag;
    logic [PROD_W-1:0]          r_p_hh;
    logic [PROD_W-1:0]          r_p_hl;
    logic [PROD_W-1:0]          r_p_ll;
    logic [VAR_W-1:0]           r_sq;
    logic                       r_vup;
    logic signed [SAMPLE_W-1:0] r_new_mean;
    t_out_item                  r_result;

    logic [IDX_W-1:0]           w_idx;
    logic [COUNT_BITS-1:0]      w_n;
    logic [COUNT_BITS-1:0]      w_den;
    logic signed [SAMPLE_W:0]   w_d;
    logic [SAMPLE_W-1:0]        w_mag;
    logic [VAR_W-1:0]           w_div_num;
    logic [VAR_W-1:0]           w_quot;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [VAR_W-1:0]           w_new_var;
    logic                       w_out_range;

    assign w_out_range = ({3'b000, r_item.sat_index} >= 9'(NUM_CHANNELS));
    assign w_idx       = IDX_W'(r_item.sat_index);

    // difference, magnitude and count from the fetched entry
    always_comb begin
        w_n   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        w_d   = {r_item.sample[SAMPLE_W-1], r_item.sample} - {r_mean[SAMPLE_W-1], r_mean};
        w_mag = w_d[SAMPLE_W] ? SAMPLE_W'(-w_d) : w_d[SAMPLE_W-1:0];
    end

    assign w_div_start = i_cmd.start_mean | i_cmd.start_var;
    assign w_div_num   = i_cmd.start_mean ? VAR_W'(r_mag)
                       : (r_vup ? r_sq - r_var : r_var - r_sq);
    assign w_den       = i_cmd.start_mean ? w_n : r_n;

    pcrmv_div #(.DEN_W(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_new_var = r_vup ? r_var + w_quot : r_var - w_quot;

    // item capture, entry fetch and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.rd_entry) begin
            r_idx  <= w_idx;
            r_arc  <= m_arc [w_idx];
            r_cnt  <= m_cnt [w_idx];
            r_mean <= m_mean[w_idx];
            r_var  <= m_var [w_idx];
        end
        if (i_cmd.start_mean) begin
            r_n    <= w_n;
            r_dneg <= w_d[SAMPLE_W];
        end
        if (i_cmd.start_var) begin
            r_new_mean <= r_dneg ? r_mean - SAMPLE_W'(w_quot)
                                 : r_mean + SAMPLE_W'(w_quot);
        end
        r_mag <= i_cmd.rd_entry ? r_mag : w_mag;
        // q.16 square of the magnitude from three half-width products
        r_p_hh <= PROD_W'(r_mag[SAMPLE_W-1:HALF_W]) * PROD_W'(r_mag[SAMPLE_W-1:HALF_W]);
        r_p_hl <= PROD_W'(r_mag[SAMPLE_W-1:HALF_W]) * PROD_W'(r_mag[HALF_W-1:0]);
        r_p_ll <= PROD_W'(r_mag[HALF_W-1:0]) * PROD_W'(r_mag[HALF_W-1:0]);
        r_sq   <= (VAR_W'(r_p_hh) << (2 * HALF_W - 16))
                + (VAR_W'(r_p_hl) << (HALF_W - 15))
                + VAR_W'(r_p_ll >> 16);
        r_vup  <= (r_sq >= r_var);
    end

    // table writes, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            m_arc [i_clr_addr[IDX_W-1:0]] <= '0;
            m_cnt [i_clr_addr[IDX_W-1:0]] <= '0;
            m_mean[i_clr_addr[IDX_W-1:0]] <= '0;
            m_var [i_clr_addr[IDX_W-1:0]] <= '0;
        end else if (i_cmd.wr_restart) begin
            m_arc [r_idx] <= r_item.arc_number;
            m_cnt [r_idx] <= COUNT_BITS'(1);
            m_mean[r_idx] <= r_item.sample;
            m_var [r_idx] <= VAR_W'(i_init_var);
        end else if (i_cmd.wr_update) begin
            m_cnt [r_idx] <= r_n;
            m_mean[r_idx] <= r_new_mean;
            m_var [r_idx] <= w_new_var;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out_rej) begin
            r_result <= '{rejected: 1'b1, mean_out: '0, variance_out: '0, restarted: 1'b0};
        end else if (i_cmd.wr_restart) begin
            r_result <= '{rejected: 1'b0, mean_out: r_item.sample,
                          variance_out: VAR_W'(i_init_var), restarted: 1'b1};
        end else if (i_cmd.wr_update) begin
            r_result <= '{rejected: 1'b0, mean_out: r_new_mean,
                          variance_out: w_new_var, restarted: 1'b0};
        end
    end

    assign o_sts.reject   = !r_item.value_present || w_out_range;
    assign o_sts.restart  = r_item.arc_present && (r_item.arc_number != r_arc);
    assign o_sts.div_done = w_div_done;
    assign o_result       = r_result;

endmodule

`default_nettype wire

[rtl/pcrmv_ctrl.sv]
// ----------------------------------------------------------------------------
// pcrmv_ctrl
// Sequencer: clearing pass, fetch, two divisions, write back, output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module pcrmv_ctrl
    import pcrmv_pkg::*;
#(
    parameter int NUM_CHANNELS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd   o_cmd,
    output logic      o_clr_en,
    output logic [7:0] o_clr_addr
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECIDE, S_SQ, S_MEAN, S_VAR, S_OUT
    } t_state;

    t_state     r_state;
    logic [7:0] r_clr;
    logic       r_out_valid;
    logic       w_take;

    assign w_take = (r_state == S_IDLE) && i_in_valid && !r_out_valid;

    // command decode
    always_comb begin
        o_cmd              = '0;
        o_cmd.load_item    = w_take;
        o_cmd.rd_entry     = (r_state == S_FETCH);
        o_cmd.start_mean   = (r_state == S_SQ);
        o_cmd.start_var    = (r_state == S_MEAN) && i_sts.div_done;
        o_cmd.load_out_rej = (r_state == S_DECIDE) && i_sts.reject;
        o_cmd.wr_restart   = (r_state == S_DECIDE) && !i_sts.reject && i_sts.restart;
        o_cmd.wr_update    = (r_state == S_VAR) && i_sts.div_done;
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == 8'(NUM_CHANNELS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH:  r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (i_sts.reject || i_sts.restart) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_MEAN;
                S_MEAN: begin
                    if (i_sts.div_done) begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (i_sts.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = !w_take;
    assign o_out_valid = r_out_valid;
    assign o_clr_en    = (r_state == S_CLEAR);
    assign o_clr_addr  = r_clr;

endmodule

`default_nettype wire

[rtl/per_channel_running_mean_variance.sv]
// ----------------------------------------------------------------------------
// per_channel_running_mean_variance
// Rejected and restarting items skip the arithmetic; an update runs two
// 64-step divisions by the count in one shared bit-serial divider. One
// item at a time; no new item is taken while a result is pending. After
// reset a clearing pass zeroes the tables; no item is taken during it.
// initial_variance resets to 4096 (0.0625 in Q.16).
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_running_mean_variance
    import pcrmv_pkg::*;
#(
    parameter int NUM_CHANNELS = 64,
    parameter int COUNT_BITS   = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_clr_en;
    logic [7:0]       w_clr_addr;
    logic [CFG_W-1:0] r_init_var;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_var <= INIT_VAR_RESET;
        end else if (i_cfg_valid) begin
            r_init_var <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    pcrmv_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_clr_en    (w_clr_en),
        .o_clr_addr  (w_clr_addr)
    );

    pcrmv_datapath #(.NUM_CHANNELS(NUM_CHANNELS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_in_data),
        .i_init_var (r_init_var),
        .i_clr_en   (w_clr_en),
        .i_clr_addr (w_clr_addr),
        .o_sts      (w_sts),
        .o_result   (o_out_data)
    );

    // a restart and an update write never coincide
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr_restart && w_cmd.wr_update))
        else $error("restart and update write together");

    // no item taken while a result is pending
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // no item taken during the clearing pass
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_en |-> o_in_stall)
        else $error("input taken during clearing");

endmodule

`default_nettype wire
